>>> sv/ffsa_pkg.sv
`default_nettype none

package ffsa_pkg;

  localparam int POOL_GRANULES = 4096;
  localparam int MAX_SEGS      = 64;
  localparam int GRAN_SHIFT    = 6;
  localparam int START_W       = 12;
  localparam int LEN_W         = 13;
  localparam int STEP_W        = 6;
  localparam int CNT_W         = 7;
  localparam int BYTES_W       = 18;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_OOM     = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic               vld;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } seg_t;

  typedef struct packed {
    logic               func;
    logic [BYTES_W-1:0] req_bytes;
    logic [BYTES_W-1:0] addr;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [BYTES_W-1:0] payload_offset;
    logic [BYTES_W-1:0] granted_bytes;
  } res_t;

  typedef struct packed {
    logic             shift;
    logic             load;
    logic [LEN_W-1:0] init_len;
  } ring_ctl_t;

endpackage

`default_nettype wire

>>> sv/ffsa_cell.sv
`default_nettype none

module ffsa_cell import ffsa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic shift,
  input  wire logic load,
  input  wire seg_t init_val,
  input  wire seg_t din,
  output seg_t      q
);

  // Hold one segment; load on reset or pool write, advance on shift
  always_ff @(posedge clk) begin
    if (rst || load) begin
      q <= init_val;
    end else if (shift) begin
      q <= din;
    end
  end

endmodule

`default_nettype wire

>>> sv/ffsa_ctrl.sv
`default_nettype none

module ffsa_ctrl import ffsa_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pool_granules_we,
  input  wire logic [LEN_W-1:0] pool_granules,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire req_t             in_req,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output res_t                  out_res,
  input  wire seg_t             cur,
  input  wire seg_t             nxt,
  output seg_t                  emit,
  output ring_ctl_t             ring
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ALOC  = 9'b000000010,
    S_AFIN  = 9'b000000100,
    S_FRD   = 9'b000001000,
    S_FCHK  = 9'b000010000,
    S_SCAN  = 9'b000100000,
    S_FDEC  = 9'b001000000,
    S_APPLY = 9'b010000000,
    S_RES   = 9'b100000000
  } state_t;

  state_t             state;
  logic [STEP_W-1:0]  step;
  logic [CNT_W-1:0]   count;
  logic [LEN_W-1:0]   pool;
  logic [LEN_W-1:0]   need;
  logic [START_W-1:0] s;
  logic [LEN_W-1:0]   flen;
  logic               found;
  logic [START_W-1:0] hs;
  logic [LEN_W-1:0]   blen;
  logic               del;
  logic               ins;
  seg_t               carry;
  logic               prev_vld;
  logic [LEN_W-1:0]   prev_end;
  logic               nxt_fnd;
  logic [START_W-1:0] nxt_start;
  logic [CNT_W-1:0]   p;
  logic               padj;
  logic               nadj;
  res_t               res;
  logic [LEN_W-1:0]   rdata;
  logic [LEN_W-1:0]   mem [POOL_GRANULES];

  logic               accept;
  logic               last;
  logic [LEN_W-1:0]   clamp;
  logic [LEN_W-1:0]   rest;
  logic               fit;
  logic [LEN_W-1:0]   send;
  logic               ovl;
  logic               padj_c;
  logic               nadj_c;
  logic [START_W-1:0] s_in;
  logic               bad_in;
  logic [LEN_W-1:0]   span;
  logic [LEN_W-1:0]   pay_g;
  logic [LEN_W-1:0]   gr_g;
  logic [LEN_W-1:0]   need_in;
  seg_t               del_emit;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign last     = (step == STEP_W'(MAX_SEGS - 1));

  // Clamp the pool size into the legal range
  always_comb begin
    if (pool_granules < LEN_W'(2)) begin
      clamp = LEN_W'(2);
    end else if (pool_granules > LEN_W'(POOL_GRANULES)) begin
      clamp = LEN_W'(POOL_GRANULES);
    end else begin
      clamp = pool_granules;
    end
  end

  assign ring.load     = pool_granules_we;
  assign ring.init_len = rst ? LEN_W'(POOL_GRANULES) : clamp;
  assign ring.shift    = (state == S_ALOC) || (state == S_SCAN) || (state == S_APPLY);

  // Round the request up to whole granules and add the header granule
  assign need_in = LEN_W'(in_req.req_bytes[BYTES_W-1:GRAN_SHIFT]) +
                   LEN_W'(in_req.req_bytes[GRAN_SHIFT-1:0] != '0) + LEN_W'(1);

  // Decode the free address
  assign s_in   = in_req.addr[BYTES_W-1:GRAN_SHIFT] - START_W'(1);
  assign bad_in = (in_req.addr == '0) || (in_req.addr[GRAN_SHIFT-1:0] != '0) ||
                  ({1'b0, s_in} >= pool);
  assign span   = pool - {1'b0, s};

  // First-fit test on the segment at the head
  assign fit  = !found && !del && cur.vld && (cur.len >= need);
  assign rest = cur.len - need;

  // Overlap and adjacency of the freed block
  assign send   = {1'b0, s} + flen;
  assign ovl    = (prev_vld && (prev_end > {1'b0, s})) ||
                  (nxt_fnd && ({1'b0, nxt_start} < send));
  assign padj_c = prev_vld && (prev_end == {1'b0, s});
  assign nadj_c = nxt_fnd && ({1'b0, nxt_start} == send);

  // Pulled-forward segment while deleting; tail slot goes empty
  always_comb begin
    if (last) begin
      del_emit = '0;
    end else begin
      del_emit = nxt;
    end
  end

  // Head logic: choose the segment fed back into the tail cell
  always_comb begin
    emit = cur;
    if (del) begin
      emit = del_emit;
    end else if (ins) begin
      emit = carry;
    end else if (state == S_ALOC && fit) begin
      if (rest >= LEN_W'(2)) begin
        emit = '{vld: 1'b1, start: cur.start + START_W'(need), len: rest};
      end else begin
        emit = del_emit;
      end
    end else if (state == S_APPLY) begin
      if (padj && ({1'b0, step} == p - CNT_W'(1))) begin
        emit = '{vld: 1'b1, start: cur.start,
                 len: cur.len + flen + (nadj ? nxt.len : LEN_W'(0))};
      end else if (!padj && ({1'b0, step} == p)) begin
        if (nadj) begin
          emit = '{vld: 1'b1, start: s, len: cur.len + flen};
        end else begin
          emit = '{vld: 1'b1, start: s, len: flen};
        end
      end
    end
  end

  assign pay_g = {1'b0, hs} + LEN_W'(1);
  assign gr_g  = blen - LEN_W'(1);

  // Block length store
  always_ff @(posedge clk) begin
    if (state == S_AFIN && found) begin
      mem[hs] <= blen;
    end
    rdata <= mem[s];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      count     <= CNT_W'(1);
      pool      <= LEN_W'(POOL_GRANULES);
      out_valid <= 1'b0;
      del       <= 1'b0;
      ins       <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_RES) begin
        out_valid <= 1'b0;
      end
      if (pool_granules_we) begin
        pool  <= clamp;
        count <= CNT_W'(1);
      end
      if (ring.shift) begin
        step <= step + STEP_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            step     <= '0;
            del      <= 1'b0;
            ins      <= 1'b0;
            found    <= 1'b0;
            prev_vld <= 1'b0;
            nxt_fnd  <= 1'b0;
            p        <= '0;
            s        <= s_in;
            need     <= need_in;
            res      <= '{status: ST_IGNORED, payload_offset: '0, granted_bytes: '0};
            if (!in_req.func) begin
              state <= (in_req.req_bytes == '0) ? S_RES : S_ALOC;
            end else begin
              state <= bad_in ? S_RES : S_FRD;
            end
          end
        end
        S_ALOC: begin
          if (fit) begin
            found <= 1'b1;
            hs    <= cur.start;
            if (rest >= LEN_W'(2)) begin
              blen <= need;
            end else begin
              blen  <= cur.len;
              del   <= 1'b1;
              count <= count - CNT_W'(1);
            end
          end
          if (last) begin
            state <= S_AFIN;
          end
        end
        S_AFIN: begin
          if (found) begin
            res <= '{status: ST_DONE,
                     payload_offset: {pay_g[START_W-1:0], GRAN_SHIFT'(0)},
                     granted_bytes: {gr_g[START_W-1:0], GRAN_SHIFT'(0)}};
          end else begin
            res.status <= ST_OOM;
          end
          state <= S_RES;
        end
        S_FRD: begin
          state <= S_FCHK;
        end
        S_FCHK: begin
          flen <= rdata;
          if (rdata == '0 || rdata > span) begin
            state <= S_RES;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cur.vld) begin
            if (cur.start < s) begin
              prev_vld <= 1'b1;
              prev_end <= {1'b0, cur.start} + cur.len;
              p        <= p + CNT_W'(1);
            end else if (!nxt_fnd) begin
              nxt_fnd   <= 1'b1;
              nxt_start <= cur.start;
            end
          end
          if (last) begin
            state <= S_FDEC;
          end
        end
        S_FDEC: begin
          padj <= padj_c;
          nadj <= nadj_c;
          if (ovl) begin
            state <= S_RES;
          end else if (!padj_c && !nadj_c && count >= CNT_W'(MAX_SEGS)) begin
            res.status <= ST_FULL;
            state      <= S_RES;
          end else begin
            res.status <= ST_DONE;
            state      <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (ins) begin
            carry <= cur;
          end else if (!del) begin
            if (padj && nadj && ({1'b0, step} == p - CNT_W'(1))) begin
              del   <= 1'b1;
              count <= count - CNT_W'(1);
            end else if (!padj && !nadj && ({1'b0, step} == p)) begin
              ins   <= 1'b1;
              carry <= cur;
              count <= count + CNT_W'(1);
            end
          end
          if (last) begin
            state <= S_RES;
          end
        end
        S_RES: begin
          if (!out_valid || !out_stall) begin
            out_res   <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/first_fit_segment_allocator.sv
// Channel  | Valid      | Stall      | Payload
// request  | in_valid   | in_stall   | in_req  (func, req_bytes, addr)
// result   | out_valid  | out_stall  | out_res (status, payload_offset, granted_bytes)
// config   | pool_granules_we         | pool_granules
// An allocation makes one full rotation of the segment ring, then a finishing step.
// A free reads the block length, then makes a scanning rotation and then an
// updating rotation. A zero request or a rejected address goes straight to the result.
// Reset is synchronous; the ring starts as one free segment covering the pool.
// A new request is taken while the previous result waits under out_stall.
`default_nettype none

module first_fit_segment_allocator import ffsa_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pool_granules_we,
  input  wire logic [LEN_W-1:0] pool_granules,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire req_t             in_req,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output res_t                  out_res
);

  seg_t      q [MAX_SEGS];
  seg_t      emit;
  ring_ctl_t ring;

  ffsa_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .pool_granules_we (pool_granules_we),
    .pool_granules    (pool_granules),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req           (in_req),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_res          (out_res),
    .cur              (q[0]),
    .nxt              (q[1]),
    .emit             (emit),
    .ring             (ring)
  );

  // Segment ring: each cell hands its entry toward the head
  for (genvar i = 0; i < MAX_SEGS; i++) begin : g_cell
    seg_t din;
    seg_t init_val;
    if (i == MAX_SEGS - 1) begin : g_tail
      assign din = emit;
    end else begin : g_mid
      assign din = q[i+1];
    end
    if (i == 0) begin : g_head
      assign init_val = '{vld: 1'b1, start: '0, len: ring.init_len};
    end else begin : g_rest
      assign init_val = '0;
    end
    ffsa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (ring.shift),
      .load     (ring.load),
      .init_val (init_val),
      .din      (din),
      .q        (q[i])
    );
  end

endmodule

`default_nettype wire
